>>> src/lfsc_pkg.sv
`default_nettype none
package lfsc_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int DIV_STEPS    = 8;
   localparam logic [11:0] DRIVE_LIMIT  = 12'd2600;
   localparam logic [12:0] RAMP_STEP    = 13'd100;
   localparam logic [11:0] INNER_SEARCH = 12'd350;
   localparam logic signed [7:0] SLOW_ERROR = 8'sd20;
   localparam logic signed [7:0] DIFF_LIMIT = 8'sd8;
   localparam logic [7:0] THIRD_MUL = 8'd171;
   localparam logic [1:0] BRAKE_TICKS = 2'd2;
   localparam logic [1:0] EXIT_TICKS  = 2'd2;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_FOLLOW = 2'd0;
   localparam mode_type MODE_SEARCH = 2'd1;
   localparam mode_type MODE_BRAKE  = 2'd2;
   localparam mode_type MODE_PIVOT  = 2'd3;

   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type CSR_BASE_DRIVE   = 3'd0;
   localparam csr_addr_type CSR_TURN_BASE    = 3'd1;
   localparam csr_addr_type CSR_PROP_GAIN    = 3'd2;
   localparam csr_addr_type CSR_DERIV_GAIN   = 3'd3;
   localparam csr_addr_type CSR_SHARP_THR    = 3'd4;
   localparam csr_addr_type CSR_SHARP_DRIVE  = 3'd5;
   localparam csr_addr_type CSR_SHARP_LOST   = 3'd6;
   localparam csr_addr_type CSR_SEARCH_OUTER = 3'd7;

   typedef struct packed {
      logic capture;
      logic load;
      logic div_step;
      logic filt;
      logic mul;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // sensor at raw bit idx carries weight 35 - 10*idx
   function automatic logic signed [6:0] weight(input logic [2:0] idx);
      logic signed [6:0] w;
      unique case (idx)
         3'd0: w = 7'sd35;
         3'd1: w = 7'sd25;
         3'd2: w = 7'sd15;
         3'd3: w = 7'sd5;
         3'd4: w = -7'sd5;
         3'd5: w = -7'sd15;
         3'd6: w = -7'sd25;
         default: w = -7'sd35;
      endcase
      return w;
   endfunction

   function automatic logic [11:0] clamp_drive(input logic signed [14:0] v);
      logic [11:0] r;
      if (v < 15'sd0) r = 12'd0;
      else if (v > $signed({3'b000, DRIVE_LIMIT})) r = DRIVE_LIMIT;
      else r = v[11:0];
      return r;
   endfunction

   function automatic logic [11:0] limit_level(input logic [11:0] v);
      return (v > DRIVE_LIMIT) ? DRIVE_LIMIT : v;
   endfunction

   function automatic logic [11:0] ramp(input logic [11:0] now, input logic [11:0] tgt);
      logic [12:0] n;
      logic [12:0] t;
      logic [12:0] r;
      n = {1'b0, now};
      t = {1'b0, tgt};
      if (n + RAMP_STEP < t) r = n + RAMP_STEP;
      else if (n > t + RAMP_STEP) r = n - RAMP_STEP;
      else r = t;
      return r[11:0];
   endfunction

endpackage
`default_nettype wire

>>> src/line_follow_steering_controller.sv
`default_nettype none
// Line-follow steering controller. Each request carries eight raw sensor levels and
// yields one response with both wheel commands (negated ramped levels), the steering
// mode and the filtered line error. A request passes from acceptance through a load
// step, the bit-serial divide of the weighted sum by the lit-sensor count (eight
// divide steps), a filter step, a multiply step and a commit step before the response
// appears. A new request is taken the cycle after commit, so no new request is taken
// while one is still in work; commit holds while an earlier response still waits,
// and the response register lets a new request in while that response waits.
module line_follow_steering_controller import lfsc_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // sensor_levels[7:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // left_drive[12:0], right_drive[25:13], mode[27:26],
                                    // filtered_error_out[34:28], zero pad[39:35]
   input  wire         csr_wen,
   input  wire  [2:0]  csr_addr,
   input  wire  [11:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic signed [12:0] left_drive, right_drive;
   mode_type mode;
   logic signed [6:0] filtered_error_out;

   lfsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfsc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .sensor_levels      (req_tdata),
      .csr_wen            (csr_wen),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .left_drive         (left_drive),
      .right_drive        (right_drive),
      .mode               (mode),
      .filtered_error_out (filtered_error_out)
   );

   assign rsp_tdata = {5'b00000, filtered_error_out, mode, right_drive, left_drive};

endmodule
`default_nettype wire

>>> src/lfsc_ctrl.sv
`default_nettype none
module lfsc_ctrl import lfsc_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_DIV, ST_FILT, ST_MUL, ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(DIV_STEPS - 1)) state_in = ST_FILT;
         end
         ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

>>> src/lfsc_datapath.sv
`default_nettype none
module lfsc_datapath import lfsc_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  wire  [7:0]        sensor_levels,
   input  wire               csr_wen,
   input  wire  [2:0]        csr_addr,
   input  wire  [11:0]       csr_wdata,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [12:0] left_drive,
   output logic signed [12:0] right_drive,
   output mode_type          mode,
   output logic signed [6:0] filtered_error_out
);

   typedef enum logic [2:0] {
      P_BRAKE_HOLD, P_PIVOT_LOST, P_PIVOT_CONF, P_PIVOT_SHARP,
      P_SEARCH, P_BRAKE_ENTER, P_FOLLOW
   } path_type;

   // configuration
   logic [11:0] base_ff, turn_base_ff, sharp_drive_ff, sharp_lost_ff, search_outer_ff;
   logic [7:0]  prop_ff, deriv_ff;
   logic [5:0]  thr_ff;

   // per-request working registers
   logic [7:0] raw_ff;
   logic       neg_ff;
   logic [3:0] cnt_ff;
   logic [7:0] dvd_ff;
   logic [2:0] rem_ff;
   logic [5:0] quo_ff;
   logic signed [6:0] err_ff, sm_ff;
   logic signed [4:0] diff_ff;
   path_type   path_ff;
   logic       exit_ff, brake_neg_ff;
   logic [1:0] ec1_ff;
   logic signed [15:0] pprod_ff;
   logic signed [13:0] dprod_ff;

   // steering state
   logic signed [1:0] td_ff;
   logic [1:0] brake_ff, ec_ff;
   logic signed [6:0] lre_ff, prev_ff, smooth_ff;
   logic seen_ff, pev_ff, sv_ff;
   logic [11:0] left_ff, right_ff;

   logic rsp_valid_ff;
   logic signed [12:0] out_left_ff, out_right_ff;
   mode_type out_mode_ff;
   logic signed [6:0] out_fe_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // weighted sum and count of the lit sensors
   logic signed [8:0] sum_c;
   logic [3:0] cnt_c;
   always_comb begin
      sum_c = '0;
      cnt_c = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (!raw_ff[i]) begin
            sum_c = sum_c + 9'(weight(3'(i)));
            cnt_c = cnt_c + 4'd1;
         end
      end
   end
   logic [8:0] sum_neg;
   assign sum_neg = 9'(-sum_c);

   // one restoring divide step per cycle
   logic [3:0] rem_sh;
   logic       q_bit;
   assign rem_sh = {rem_ff, dvd_ff[7]};
   assign q_bit  = (rem_sh >= cnt_ff);

   // error, filter and derivative
   logic signed [6:0] err_c, sm_c, sm_div;
   logic signed [7:0] err8, thr8, d8;
   logic signed [8:0] v9;
   logic [7:0] m8;
   logic [15:0] third_prod;
   logic [6:0] q7;
   logic hit_neg, hit_pos, centre, small_err, exit_c;
   logic [1:0] ec1_c;
   path_type path_c;
   logic signed [4:0] diff_c;

   always_comb begin
      err_c = (cnt_ff == 4'd0) ? 7'sd0 :
              (neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff}));
      err8  = {err_c[6], err_c};
      thr8  = $signed({2'b00, thr_ff});
      hit_neg = (-err8) >= thr8;
      hit_pos = err8 >= thr8;
      centre  = |(~raw_ff[5:2]);
      small_err = (err8 <= SLOW_ERROR) && (err8 >= -SLOW_ERROR);
      ec1_c = ec_ff + 2'd1;
      exit_c = 1'b0;
      if (td_ff != 2'sd0) begin
         if (brake_ff != 2'd0) path_c = P_BRAKE_HOLD;
         else if (cnt_ff == 4'd0) path_c = P_PIVOT_LOST;
         else if (centre && small_err) begin
            if (ec1_c >= EXIT_TICKS) begin
               exit_c = 1'b1;
               path_c = (hit_neg || hit_pos) ? P_BRAKE_ENTER : P_FOLLOW;
            end else begin
               path_c = P_PIVOT_CONF;
            end
         end else path_c = P_PIVOT_SHARP;
      end else if (cnt_ff == 4'd0) path_c = P_SEARCH;
      else if (hit_neg || hit_pos) path_c = P_BRAKE_ENTER;
      else path_c = P_FOLLOW;

      // (2f + e) / 3 toward zero, by reciprocal
      v9 = ({{2{smooth_ff[6]}}, smooth_ff} <<< 1) + {{2{err_c[6]}}, err_c};
      m8 = v9[8] ? 8'(-v9) : v9[7:0];
      third_prod = m8 * THIRD_MUL;
      q7 = third_prod[15:9];
      sm_div = v9[8] ? -$signed(q7) : $signed(q7);
      sm_c = (exit_c || !sv_ff) ? err_c : sm_div;

      d8 = {sm_c[6], sm_c} - {prev_ff[6], prev_ff};
      if (exit_c || !pev_ff) diff_c = 5'sd0;
      else if (d8 > DIFF_LIMIT) diff_c = 5'sd8;
      else if (d8 < -DIFF_LIMIT) diff_c = -5'sd8;
      else diff_c = d8[4:0];
   end

   // commit: correction, targets, ramp
   logic signed [16:0] corr_sum;
   logic signed [12:0] corr;
   logic [11:0] base_c, lt, rt, left_new, right_new, piv_level;
   logic signed [14:0] a15, b15;
   logic zero_levels;
   mode_type mode_c;

   always_comb begin
      corr_sum = {pprod_ff[15], pprod_ff} + {{3{dprod_ff[13]}}, dprod_ff};
      if (corr_sum > 17'sd2600) corr = 13'sd2600;
      else if (corr_sum < -17'sd2600) corr = -13'sd2600;
      else corr = corr_sum[12:0];
      base_c = (sm_ff > 7'sd20 || sm_ff < -7'sd20) ? turn_base_ff : base_ff;
      a15 = $signed({3'b000, base_c}) + {{2{corr[12]}}, corr};
      b15 = $signed({3'b000, base_c}) - {{2{corr[12]}}, corr};

      piv_level = (path_ff == P_PIVOT_SHARP) ? limit_level(sharp_drive_ff)
                                             : limit_level(sharp_lost_ff);
      lt = '0;
      rt = '0;
      zero_levels = 1'b0;
      mode_c = MODE_FOLLOW;
      case (path_ff)
         P_BRAKE_HOLD, P_BRAKE_ENTER: begin
            zero_levels = 1'b1;
            mode_c = MODE_BRAKE;
         end
         P_PIVOT_LOST, P_PIVOT_CONF, P_PIVOT_SHARP: begin
            mode_c = MODE_PIVOT;
            if (td_ff < 2'sd0) lt = piv_level;
            else rt = piv_level;
         end
         P_SEARCH: begin
            mode_c = MODE_SEARCH;
            if (!seen_ff) begin
               lt = limit_level(search_outer_ff);
               rt = limit_level(search_outer_ff);
            end else if ($signed({lre_ff[6], lre_ff}) <= -thr8) lt = limit_level(sharp_lost_ff);
            else if ($signed({lre_ff[6], lre_ff}) >= thr8) rt = limit_level(sharp_lost_ff);
            else if (lre_ff < 7'sd0) begin
               lt = limit_level(search_outer_ff);
               rt = INNER_SEARCH;
            end else begin
               lt = INNER_SEARCH;
               rt = limit_level(search_outer_ff);
            end
         end
         default: begin
            lt = clamp_drive(b15);
            rt = clamp_drive(a15);
         end
      endcase
      left_new  = zero_levels ? 12'd0 : ramp(left_ff, lt);
      right_new = zero_levels ? 12'd0 : ramp(right_ff, rt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 12'd1500;  turn_base_ff <= 12'd1100;
         prop_ff <= 8'd28;     deriv_ff <= 8'd4;
         thr_ff  <= 6'd30;     sharp_drive_ff <= 12'd1750;
         sharp_lost_ff <= 12'd2050; search_outer_ff <= 12'd1200;
         td_ff <= '0; brake_ff <= '0; ec_ff <= '0;
         lre_ff <= '0; seen_ff <= 1'b0; prev_ff <= '0; pev_ff <= 1'b0;
         smooth_ff <= '0; sv_ff <= 1'b0; left_ff <= '0; right_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_BASE_DRIVE:   base_ff <= csr_wdata;
               CSR_TURN_BASE:    turn_base_ff <= csr_wdata;
               CSR_PROP_GAIN:    prop_ff <= csr_wdata[7:0];
               CSR_DERIV_GAIN:   deriv_ff <= csr_wdata[7:0];
               CSR_SHARP_THR:    thr_ff <= csr_wdata[5:0];
               CSR_SHARP_DRIVE:  sharp_drive_ff <= csr_wdata;
               CSR_SHARP_LOST:   sharp_lost_ff <= csr_wdata;
               CSR_SEARCH_OUTER: search_outer_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            left_ff  <= left_new;
            right_ff <= right_new;
            case (path_ff)
               P_BRAKE_HOLD: brake_ff <= brake_ff - 2'd1;
               P_PIVOT_LOST: begin
                  ec_ff <= '0;
                  pev_ff <= 1'b0;
               end
               P_PIVOT_CONF: begin
                  lre_ff <= err_ff; seen_ff <= 1'b1; ec_ff <= ec1_ff;
               end
               P_PIVOT_SHARP: begin
                  lre_ff <= err_ff; seen_ff <= 1'b1; ec_ff <= '0;
               end
               P_SEARCH: begin
                  pev_ff <= 1'b0;
                  sv_ff <= 1'b0;
               end
               P_BRAKE_ENTER: begin
                  // a pivot exit preloads the filter before the new pivot starts
                  if (exit_ff) smooth_ff <= err_ff;
                  lre_ff <= err_ff; seen_ff <= 1'b1;
                  td_ff <= brake_neg_ff ? -2'sd1 : 2'sd1;
                  brake_ff <= BRAKE_TICKS; ec_ff <= '0;
                  prev_ff <= err_ff; sv_ff <= 1'b0;
               end
               default: begin
                  lre_ff <= err_ff; seen_ff <= 1'b1;
                  if (exit_ff) begin
                     td_ff <= '0;
                     ec_ff <= '0;
                  end
                  smooth_ff <= sm_ff; sv_ff <= 1'b1;
                  prev_ff <= sm_ff; pev_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) raw_ff <= sensor_levels;
      if (cmd.load) begin
         neg_ff <= sum_c[8];
         cnt_ff <= cnt_c;
         dvd_ff <= sum_c[8] ? sum_neg[7:0] : sum_c[7:0];
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= q_bit ? 3'(rem_sh - cnt_ff) : rem_sh[2:0];
         quo_ff <= {quo_ff[4:0], q_bit};
         dvd_ff <= {dvd_ff[6:0], 1'b0};
      end
      if (cmd.filt) begin
         err_ff <= err_c;
         sm_ff <= sm_c;
         diff_ff <= diff_c;
         path_ff <= path_c;
         exit_ff <= exit_c;
         ec1_ff <= ec1_c;
         brake_neg_ff <= hit_neg;
      end
      if (cmd.mul) begin
         pprod_ff <= sm_ff * $signed({1'b0, prop_ff});
         dprod_ff <= diff_ff * $signed({1'b0, deriv_ff});
      end
      if (cmd.commit) begin
         out_left_ff  <= -$signed({1'b0, left_new});
         out_right_ff <= -$signed({1'b0, right_new});
         out_mode_ff  <= mode_c;
         out_fe_ff    <= (path_ff == P_FOLLOW) ? sm_ff :
                         ((path_ff == P_BRAKE_ENTER && exit_ff) ? err_ff : smooth_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign left_drive         = out_left_ff;
   assign right_drive        = out_right_ff;
   assign mode               = out_mode_ff;
   assign filtered_error_out = out_fe_ff;

endmodule
`default_nettype wire

>>> src/lfsc_checker.sv
`default_nettype none
module lfsc_checker import lfsc_pkg::*; (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata
);

   logic signed [12:0] left_d, right_d;
   logic signed [6:0]  fe;
   assign left_d  = rsp_tdata[12:0];
   assign right_d = rsp_tdata[25:13];
   assign fe      = rsp_tdata[34:28];

   // one request at a time: busy right after acceptance
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_brake_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27:26] == MODE_BRAKE |-> left_d == 13'sd0 && right_d == 13'sd0)
      else $error("brake response with nonzero drive");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> left_d <= 13'sd0 && left_d >= -13'sd2600 &&
                     right_d <= 13'sd0 && right_d >= -13'sd2600 &&
                     fe <= 7'sd35 && fe >= -7'sd35)
      else $error("response field out of range");

endmodule

bind line_follow_steering_controller lfsc_checker u_lfsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

>>> tb/steering_checker.sv
`timescale 1ns / 100ps
module steering_checker import lfsc_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [7:0]  req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [39:0] rsp_tdata,
   input  wire         csr_wen,
   input  wire  [2:0]  csr_addr,
   input  wire  [11:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic signed [12:0] left_drive;
      logic signed [12:0] right_drive;
      mode_type           mode;
      logic signed [6:0]  filt_err;
   } steer_out_t;

   steer_out_t pending_q[$];

   int base_lvl, turn_base_lvl, kp, kd, thr_cfg, sharp_lvl, lost_lvl, search_lvl;
   int turn_dir, brake_cnt, exit_cnt, last_raw, prev_err, smooth_err, left_lvl, right_lvl;
   bit seen, prev_ok, smooth_ok;

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int step_toward(int now, int tgt);
      if (now < tgt - 100) return now + 100;
      if (now > tgt + 100) return now - 100;
      return tgt;
   endfunction

   // steering order in; the wheels are swapped here
   task automatic set_wheels(int a, int b);
      left_lvl  = step_toward(left_lvl, clip(b, 0, 2600));
      right_lvl = step_toward(right_lvl, clip(a, 0, 2600));
   endtask

   task automatic pivot_wheels(int lvl);
      if (turn_dir < 0) set_wheels(0, lvl);
      else if (turn_dir > 0) set_wheels(lvl, 0);
   endtask

   task automatic search_wheels();
      if (!seen) set_wheels(search_lvl, search_lvl);
      else if (turn_dir < 0 || last_raw <= -thr_cfg) set_wheels(0, lost_lvl);
      else if (turn_dir > 0 || last_raw >= thr_cfg) set_wheels(lost_lvl, 0);
      else if (last_raw < 0) set_wheels(350, search_lvl);
      else set_wheels(search_lvl, 350);
   endtask

   task automatic predict_steer(logic [7:0] raw);
      logic [7:0] lit;
      int sum, cnt, e, diff, base, corr;
      mode_type m;
      steer_out_t r;
      bit done;
      sum = 0; cnt = 0; e = 0; done = 0; m = MODE_FOLLOW;
      // raw bit i low means black; weight 35 - 10*i
      for (int i = 0; i < 8; i++) begin
         lit[i] = ~raw[i];
         if (lit[i]) begin
            sum += 35 - 10 * i; cnt++;
         end
      end
      if (cnt > 0) e = sum / cnt;
      if (turn_dir != 0) begin
         if (brake_cnt > 0) begin
            brake_cnt--; left_lvl = 0; right_lvl = 0; m = MODE_BRAKE; done = 1;
         end else if (cnt == 0) begin
            exit_cnt = 0; prev_ok = 0; pivot_wheels(lost_lvl); m = MODE_PIVOT; done = 1;
         end else begin
            last_raw = e; seen = 1;
            // centre mask in mirrored order covers raw bits 2..5
            if ((lit[5:2] != 0) && e <= 20 && e >= -20) begin
               exit_cnt = (exit_cnt + 1) & 3;
               if (exit_cnt >= 2) begin
                  turn_dir = 0; exit_cnt = 0; prev_err = e; smooth_err = e; smooth_ok = 1;
               end else begin
                  pivot_wheels(lost_lvl); m = MODE_PIVOT; done = 1;
               end
            end else begin
               exit_cnt = 0; pivot_wheels(sharp_lvl); m = MODE_PIVOT; done = 1;
            end
         end
      end
      if (!done) begin
         if (cnt == 0) begin
            prev_ok = 0; smooth_ok = 0; search_wheels(); m = MODE_SEARCH;
         end else begin
            last_raw = e; seen = 1;
            if (e <= -thr_cfg || e >= thr_cfg) begin
               turn_dir = (e <= -thr_cfg) ? -1 : 1;
               brake_cnt = 2; exit_cnt = 0; prev_err = e; smooth_ok = 0;
               left_lvl = 0; right_lvl = 0; m = MODE_BRAKE;
            end else begin
               if (!smooth_ok) begin
                  smooth_err = e; smooth_ok = 1;
               end else smooth_err = (smooth_err * 2 + e) / 3;
               if (!prev_ok) begin
                  diff = 0; prev_ok = 1;
               end else diff = clip(smooth_err - prev_err, -8, 8);
               prev_err = smooth_err;
               base = (smooth_err > 20 || smooth_err < -20) ? turn_base_lvl : base_lvl;
               corr = clip(smooth_err * kp + diff * kd, -2600, 2600);
               set_wheels(base + corr, base - corr);
               m = MODE_FOLLOW;
            end
         end
      end
      r.left_drive = 13'(-left_lvl);
      r.right_drive = 13'(-right_lvl);
      r.mode = m;
      r.filt_err = 7'(smooth_err);
      pending_q.push_back(r);
   endtask

   always @(posedge clock) begin
      steer_out_t got, want;
      if (reset) begin
         base_lvl = 1500; turn_base_lvl = 1100; kp = 28; kd = 4; thr_cfg = 30;
         sharp_lvl = 1750; lost_lvl = 2050; search_lvl = 1200;
         turn_dir = 0; brake_cnt = 0; exit_cnt = 0; last_raw = 0; seen = 0;
         prev_err = 0; prev_ok = 0; smooth_err = 0; smooth_ok = 0;
         left_lvl = 0; right_lvl = 0;
         pending_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_BASE_DRIVE:   base_lvl = csr_wdata;
               CSR_TURN_BASE:    turn_base_lvl = csr_wdata;
               CSR_PROP_GAIN:    kp = csr_wdata[7:0];
               CSR_DERIV_GAIN:   kd = csr_wdata[7:0];
               CSR_SHARP_THR:    thr_cfg = csr_wdata[5:0];
               CSR_SHARP_DRIVE:  sharp_lvl = csr_wdata;
               CSR_SHARP_LOST:   lost_lvl = csr_wdata;
               CSR_SEARCH_OUTER: search_lvl = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[34:28], rsp_tdata[27:26], rsp_tdata[25:13], rsp_tdata[12:0]};
            got.left_drive = rsp_tdata[12:0];
            got.right_drive = rsp_tdata[25:13];
            got.mode = rsp_tdata[27:26];
            got.filt_err = rsp_tdata[34:28];
            if (pending_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_q.pop_front();
               if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive
                   || got.mode !== want.mode || got.filt_err !== want.filt_err
                   || rsp_tdata[39:35] !== 5'd0) begin
                  $display("%0t: mismatch expected L=%0d R=%0d mode=%0d err=%0d, actual L=%0d R=%0d mode=%0d err=%0d pad=%b",
                           $time, want.left_drive, want.right_drive, want.mode, want.filt_err,
                           got.left_drive, got.right_drive, got.mode, got.filt_err,
                           rsp_tdata[39:35]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) predict_steer(req_tdata);
      end
      pending_count <= pending_q.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
   import lfsc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic [7:0]  req_tdata = 0;
   logic        rsp_tready = 0;
   logic        csr_wen = 0;
   logic [2:0]  csr_addr = 0;
   logic [11:0] csr_wdata = 0;
   wire         req_tready, rsp_tvalid;
   wire  [39:0] rsp_tdata;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   bit          calm = 0;      // no random idling
   bit          hold_sink = 0; // long receiver hold-off
   bit          stim_done = 0;

   line_follow_steering_controller uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   steering_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_sink) rsp_tready <= 0;
      else rsp_tready <= calm || ($urandom_range(99) >= 27);
   end

   // valid stays high after acceptance unless an idle cycle or a drain follows
   task automatic send_request(logic [7:0] v);
      csr_wen <= 0;
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // enable stays high across back-to-back writes; the next request drops it
   task automatic write_reg(csr_addr_type a, logic [11:0] v);
      csr_wen <= 1; csr_addr <= a; csr_wdata <= v;
      @(posedge clock);
   endtask

   // a line blob: contiguous black sensors (low bits) at a random place
   function automatic logic [7:0] line_pattern();
      int w, p;
      logic [7:0] m;
      w = $urandom_range(1, 3);
      p = $urandom_range(0, 8 - w);
      m = 8'(((1 << w) - 1) << p);
      return ~m;
   endfunction

   task automatic random_phase(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 70) send_request(line_pattern());
         else if (k < 80) send_request(8'hFF);
         else send_request(8'($urandom));
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = {8'hFF, 8'h00, 8'hE7, 8'hE7, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'hFF, 8'hF3,
                  8'hE7, 8'hE7, 8'h7F, 8'hBF, 8'hFF, 8'hE7, 8'hCF, 8'h55, 8'hAA, 8'h33,
                  8'hCC, 8'hEF, 8'hF7};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_request(directed[i]);
      drain();
      random_phase(300);
      drain();
      // extremes
      write_reg(CSR_BASE_DRIVE, 12'hFFF);
      write_reg(CSR_TURN_BASE, 12'd0);
      write_reg(CSR_PROP_GAIN, 12'd255);
      write_reg(CSR_DERIV_GAIN, 12'd255);
      write_reg(CSR_SHARP_THR, 12'd1);
      write_reg(CSR_SHARP_DRIVE, 12'hFFF);
      write_reg(CSR_SHARP_LOST, 12'd0);
      write_reg(CSR_SEARCH_OUTER, 12'hFFF);
      calm = 1;
      random_phase(250);
      calm = 0;
      drain();
      write_reg(CSR_BASE_DRIVE, 12'd0);
      write_reg(CSR_TURN_BASE, 12'd2600);
      write_reg(CSR_PROP_GAIN, 12'd0);
      write_reg(CSR_DERIV_GAIN, 12'd0);
      write_reg(CSR_SHARP_THR, 12'd63);
      write_reg(CSR_SHARP_DRIVE, 12'd0);
      write_reg(CSR_SHARP_LOST, 12'hFFF);
      write_reg(CSR_SEARCH_OUTER, 12'd0);
      random_phase(250);
      drain();
      write_reg(CSR_SHARP_THR, 12'd0);
      random_phase(100);
      drain();
      for (int j = 0; j < 4; j++) begin
         for (int r = 0; r < 8; r++) write_reg(csr_addr_type'(r), 12'($urandom));
         write_reg(CSR_SHARP_THR, 12'($urandom_range(1, 35)));
         random_phase(230);
         drain();
      end
      stim_done = 1;
   end

   // receiver hold-off while the sender keeps offering
   initial begin
      wait (cycle_count > 3000);
      @(posedge clock);
      hold_sink = 1;
      repeat (300) @(posedge clock);
      hold_sink = 0;
   end

   initial begin
      wait (stim_done);
      drain();
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
src/lfsc_pkg.sv
src/lfsc_ctrl.sv
src/lfsc_datapath.sv
src/line_follow_steering_controller.sv
src/lfsc_checker.sv
tb/steering_checker.sv
tb/testbench.sv
